>>> src/ofsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofsc_pkg
// Types, event codes and helpers shared by the object file stream checker.
// ----------------------------------------------------------------------------
package ofsc_pkg;

	localparam int OFFSET_W = 17;
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
	localparam logic [15:0] EXT_MAX = 16'hffff;

	// Event codes reported with each word.
	localparam logic [4:0] EV_MAGIC        = 5'd0;
	localparam logic [4:0] EV_GLOBAL_CHAR  = 5'd1;
	localparam logic [4:0] EV_GLOBAL_END   = 5'd2;
	localparam logic [4:0] EV_VALUE_LOW    = 5'd3;
	localparam logic [4:0] EV_VALUE_DONE   = 5'd4;
	localparam logic [4:0] EV_LENGTH_LOW   = 5'd5;
	localparam logic [4:0] EV_LENGTH_DONE  = 5'd6;
	localparam logic [4:0] EV_EXT_CHAR     = 5'd7;
	localparam logic [4:0] EV_EXT_END      = 5'd8;
	localparam logic [4:0] EV_EXTS_DONE    = 5'd9;
	localparam logic [4:0] EV_RUN_HEADER   = 5'd10;
	localparam logic [4:0] EV_STATIC_BYTE  = 5'd11;
	localparam logic [4:0] EV_RELOC        = 5'd12;
	localparam logic [4:0] EV_EXT_REF      = 5'd13;
	localparam logic [4:0] EV_EXT_REF_OFS  = 5'd14;
	localparam logic [4:0] EV_OPERAND      = 5'd15;
	localparam logic [4:0] EV_UNKNOWN_CODE = 5'd16;
	localparam logic [4:0] EV_END_MARKER   = 5'd17;
	localparam logic [4:0] EV_TRAILING     = 5'd18;
	localparam logic [4:0] EV_SUMMARY      = 5'd19;
	localparam logic [4:0] EV_GLOBALS_DONE = 5'd20;

	localparam logic [3:0] NIB_MASK_HI_D = 4'hd;
	localparam logic [3:0] NIB_HI_C      = 4'hc;

	typedef enum logic [8:0] {
		PH_MAGIC   = 9'b0_0000_0001,
		PH_GLOBAL  = 9'b0_0000_0010,
		PH_GVALUE  = 9'b0_0000_0100,
		PH_LENGTH  = 9'b0_0000_1000,
		PH_EXTERN  = 9'b0_0001_0000,
		PH_FRAG    = 9'b0_0010_0000,
		PH_RUN     = 9'b0_0100_0000,
		PH_OPERAND = 9'b0_1000_0000,
		PH_AFTER   = 9'b1_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [1:0]          byte_pos;
		logic [6:0]          run_rem;
		logic [7:0]          low_hold;
		logic [15:0]         first_word;
		logic [15:0]         decl_len;
		logic [OFFSET_W-1:0] offset_cnt;
		logic [15:0]         ext_cnt;
		logic [7:0]          frag_code;
		logic                in_name;
		logic                finished;
	} ofsc_state_t;

	localparam ofsc_state_t STATE_RESET = '{
		phase:      PH_MAGIC,
		byte_pos:   2'd0,
		run_rem:    7'd0,
		low_hold:   8'd0,
		first_word: 16'd0,
		decl_len:   16'd0,
		offset_cnt: '0,
		ext_cnt:    16'd0,
		frag_code:  8'd0,
		in_name:    1'b0,
		finished:   1'b0
	};

	typedef struct packed {
		logic [4:0]          event_res;
		logic [15:0]         word_value;
		logic [15:0]         offset_value;
		logic [OFFSET_W-1:0] code_offset;
		logic [15:0]         external_number;
		logic                unknown_pattern;
		logic                unexpected_end;
		logic                missing_end_marker;
		logic                too_long;
		logic                length_mismatch;
	} ofsc_result_t;

	// Saturating add of a byte-sized increment to the code offset.
	function automatic logic [OFFSET_W-1:0] sat_add(input logic [OFFSET_W-1:0] a,
		input logic [7:0] n);
		logic [OFFSET_W:0] s;
		s = {1'b0, a} + {{(OFFSET_W-7){1'b0}}, n};
		return s[OFFSET_W] ? OFFSET_MAX : s[OFFSET_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> src/ofsc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofsc_step
// Next state and result for one input word of the object file parser.
// ----------------------------------------------------------------------------
module ofsc_step (
	input  wire ofsc_pkg::ofsc_state_t  cur,
	input  wire logic [7:0]             byte_value,
	input  wire logic                   end_of_input,
	output ofsc_pkg::ofsc_state_t       nxt,
	output ofsc_pkg::ofsc_result_t      res
);

	logic [1:0]  bp_inc;
	logic [15:0] op_word;
	logic [15:0] byte_word;
	logic [6:0]  run_dec;
	logic        mism;

	assign bp_inc    = cur.byte_pos + 2'd1;
	assign op_word   = {byte_value, cur.low_hold};
	assign byte_word = {8'd0, byte_value};
	assign run_dec   = cur.run_rem - 7'd1;
	assign mism      = cur.offset_cnt != {1'b0, cur.decl_len};

	always_comb begin
		nxt = cur;
		res = '0;
		if (end_of_input) begin
			res.event_res       = ofsc_pkg::EV_SUMMARY;
			res.word_value      = cur.decl_len;
			res.code_offset     = cur.offset_cnt;
			res.external_number = cur.ext_cnt;
			case (cur.phase)
				ofsc_pkg::PH_AFTER: begin
					res.too_long        = cur.finished;
					res.length_mismatch = mism;
				end
				ofsc_pkg::PH_FRAG: begin
					res.missing_end_marker = 1'b1;
					res.length_mismatch    = mism;
				end
				default: res.unexpected_end = 1'b1;
			endcase
			nxt = ofsc_pkg::STATE_RESET;
		end else begin
			case (cur.phase)
				ofsc_pkg::PH_MAGIC: begin
					res.event_res = ofsc_pkg::EV_MAGIC;
					res.word_value = byte_word;
					if (bp_inc == 2'd3) begin
						nxt.byte_pos = 2'd0;
						nxt.phase    = ofsc_pkg::PH_GLOBAL;
					end else begin
						nxt.byte_pos = bp_inc;
					end
				end
				ofsc_pkg::PH_GLOBAL: begin
					if (byte_value != 8'd0) begin
						res.event_res  = ofsc_pkg::EV_GLOBAL_CHAR;
						res.word_value = byte_word;
						nxt.in_name    = 1'b1;
					end else if (cur.in_name) begin
						res.event_res = ofsc_pkg::EV_GLOBAL_END;
						nxt.in_name   = 1'b0;
						nxt.byte_pos  = 2'd0;
						nxt.phase     = ofsc_pkg::PH_GVALUE;
					end else begin
						res.event_res = ofsc_pkg::EV_GLOBALS_DONE;
						nxt.byte_pos  = 2'd0;
						nxt.phase     = ofsc_pkg::PH_LENGTH;
					end
				end
				ofsc_pkg::PH_GVALUE: begin
					if (cur.byte_pos == 2'd0) begin
						res.event_res  = ofsc_pkg::EV_VALUE_LOW;
						res.word_value = byte_word;
						nxt.low_hold   = byte_value;
						nxt.byte_pos   = 2'd1;
					end else begin
						res.event_res  = ofsc_pkg::EV_VALUE_DONE;
						res.word_value = op_word;
						nxt.byte_pos   = 2'd0;
						nxt.phase      = ofsc_pkg::PH_GLOBAL;
					end
				end
				ofsc_pkg::PH_LENGTH: begin
					if (cur.byte_pos == 2'd0) begin
						res.event_res  = ofsc_pkg::EV_LENGTH_LOW;
						res.word_value = byte_word;
						nxt.low_hold   = byte_value;
						nxt.byte_pos   = 2'd1;
					end else begin
						res.event_res  = ofsc_pkg::EV_LENGTH_DONE;
						res.word_value = op_word;
						nxt.decl_len   = op_word;
						nxt.byte_pos   = 2'd0;
						nxt.phase      = ofsc_pkg::PH_EXTERN;
					end
				end
				ofsc_pkg::PH_EXTERN: begin
					if (byte_value != 8'd0) begin
						res.event_res  = ofsc_pkg::EV_EXT_CHAR;
						res.word_value = byte_word;
						nxt.in_name    = 1'b1;
					end else if (cur.in_name) begin
						res.event_res = ofsc_pkg::EV_EXT_END;
						nxt.in_name   = 1'b0;
						if (cur.ext_cnt != ofsc_pkg::EXT_MAX) begin
							nxt.ext_cnt = cur.ext_cnt + 16'd1;
						end
					end else begin
						res.event_res = ofsc_pkg::EV_EXTS_DONE;
						nxt.phase     = ofsc_pkg::PH_FRAG;
					end
				end
				ofsc_pkg::PH_FRAG: begin
					res.word_value = byte_word;
					case (byte_value) inside
						8'h00: begin
							res.event_res = ofsc_pkg::EV_END_MARKER;
							res.word_value = 16'd0;
							nxt.phase     = ofsc_pkg::PH_AFTER;
						end
						[8'h01:8'h7f]: begin
							res.event_res  = ofsc_pkg::EV_RUN_HEADER;
							nxt.offset_cnt = ofsc_pkg::sat_add(cur.offset_cnt, byte_value);
							nxt.run_rem    = byte_value[6:0];
							nxt.phase      = ofsc_pkg::PH_RUN;
						end
						[8'h80:8'h8f], [8'hc0:8'hdf]: begin
							res.event_res = ofsc_pkg::EV_OPERAND;
							nxt.frag_code = byte_value;
							nxt.byte_pos  = 2'd0;
							nxt.phase     = ofsc_pkg::PH_OPERAND;
						end
						default: res.event_res = ofsc_pkg::EV_UNKNOWN_CODE;
					endcase
				end
				ofsc_pkg::PH_RUN: begin
					res.event_res  = ofsc_pkg::EV_STATIC_BYTE;
					res.word_value = byte_word;
					nxt.run_rem    = run_dec;
					if (run_dec == 7'd0) begin
						nxt.phase = ofsc_pkg::PH_FRAG;
					end
				end
				ofsc_pkg::PH_OPERAND: begin
					if (cur.byte_pos == 2'd0 || cur.byte_pos == 2'd2) begin
						res.event_res  = ofsc_pkg::EV_OPERAND;
						res.word_value = byte_word;
						nxt.low_hold   = byte_value;
						nxt.byte_pos   = bp_inc;
					end else if (cur.byte_pos == 2'd1
						&& cur.frag_code[7:4] == ofsc_pkg::NIB_MASK_HI_D) begin
						res.event_res  = ofsc_pkg::EV_OPERAND;
						res.word_value = byte_word;
						nxt.first_word = op_word;
						nxt.byte_pos   = 2'd2;
					end else begin
						// Final operand byte: report the fragment and apply its pattern.
						if (cur.byte_pos == 2'd1) begin
							res.event_res  = (cur.frag_code[7:4] == ofsc_pkg::NIB_HI_C)
								? ofsc_pkg::EV_EXT_REF : ofsc_pkg::EV_RELOC;
							res.word_value = op_word;
						end else begin
							res.event_res    = ofsc_pkg::EV_EXT_REF_OFS;
							res.word_value   = cur.first_word;
							res.offset_value = op_word;
						end
						case (cur.frag_code[3:0]) inside
							4'd1, 4'd2: nxt.offset_cnt = ofsc_pkg::sat_add(cur.offset_cnt, 8'd1);
							4'd3:       nxt.offset_cnt = ofsc_pkg::sat_add(cur.offset_cnt, 8'd2);
							default:    res.unknown_pattern = 1'b1;
						endcase
						nxt.byte_pos = 2'd0;
						nxt.phase    = ofsc_pkg::PH_FRAG;
					end
				end
				default: begin
					res.event_res  = ofsc_pkg::EV_TRAILING;
					res.word_value = byte_word;
					res.too_long   = 1'b1;
					nxt.finished   = 1'b1;
				end
			endcase
			res.code_offset     = nxt.offset_cnt;
			res.external_number = nxt.ext_cnt;
		end
	end

endmodule
`default_nettype wire

>>> src/object_file_stream_checker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// object_file_stream_checker_core
// Byte-serial checker for relocatable object files, one event per byte.
// ----------------------------------------------------------------------------
// Each accepted word is one byte of the file, or an end of input flag, and
// yields exactly one event word in the next cycle from the output register.
// A new word can be taken in every cycle in which the output register is empty
// or is being read; the input stalls only when the output register is full and
// stalled. The rate is one word per cycle, set by the single parser step
// that updates the parse state and loads the event register together.
// After the end summary the parser is back in its reset state for a new file.
module object_file_stream_checker_core (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        in_valid,
	output logic              in_stall,
	input  wire  logic [7:0]  byte_value,
	input  wire  logic        end_of_input,
	output logic              out_valid,
	input  wire  logic        out_stall,
	output logic [4:0]        event_res,
	output logic [15:0]       word_value,
	output logic [15:0]       offset_value,
	output logic [16:0]       code_offset,
	output logic [15:0]       external_number,
	output logic              unknown_pattern,
	output logic              unexpected_end,
	output logic              missing_end_marker,
	output logic              too_long,
	output logic              length_mismatch
);

	ofsc_pkg::ofsc_state_t  state_q;
	ofsc_pkg::ofsc_state_t  state_nxt;
	ofsc_pkg::ofsc_result_t res_nxt;
	ofsc_pkg::ofsc_result_t res_q;
	logic                   out_valid_q;
	logic                   accept;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	ofsc_step u_step (
		.cur          (state_q),
		.byte_value   (byte_value),
		.end_of_input (end_of_input),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ofsc_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid          = out_valid_q;
	assign event_res          = res_q.event_res;
	assign word_value         = res_q.word_value;
	assign offset_value       = res_q.offset_value;
	assign code_offset        = res_q.code_offset;
	assign external_number    = res_q.external_number;
	assign unknown_pattern    = res_q.unknown_pattern;
	assign unexpected_end     = res_q.unexpected_end;
	assign missing_end_marker = res_q.missing_end_marker;
	assign too_long           = res_q.too_long;
	assign length_mismatch    = res_q.length_mismatch;

endmodule
`default_nettype wire
